>>> hdl/acma_pkg.sv
// Shared constants and the store control type for the multichannel moving-average block.
`timescale 1ns / 1ps

package acma_pkg;

  localparam int DEF_CHANNELS    = 8;
  localparam int DEF_TAPS        = 8;
  localparam int DEF_SAMPLE_BITS = 12;

  // Control from the sequencer to the store.
  typedef struct packed {
    logic rd_en;    // read old tap and channel sum, capture the incoming word
    logic wr_en;    // write back new tap and updated sum
    logic smp_lap;  // sample ring has been filled once: old tap is live
    logic sum_lap;  // every channel has taken a word: stored sum is live
  } store_ctl_t;

endpackage

>>> hdl/multichannel_adc_moving_average_top.sv
// Top level of the round-robin multichannel boxcar moving average.
`timescale 1ns / 1ps

// Each accepted word is one converter sample for the current channel, which
// steps round-robin from 0 to CHANNELS-1 and wraps. The block keeps the last
// TAPS samples of every channel and returns, per word, the channel number and
// the floor of the mean of that channel's last TAPS samples; samples not yet
// taken count as zero, so the first averages ramp up from zero. Each accepted
// word holds off the next: the sample ring and the running-sum memory are read
// in the accept cycle and written back in the next, and in_stall stays high
// for that write-back cycle. Each result is written into the divide stage
// register in the write-back cycle and moves on, divided, into the output
// register, which drives out_valid; the output register lets the next word in
// while a result still waits, and in_stall rises further only when the divide
// stage is full behind a stalled output. No clearing pass is needed after
// reset: fill flags make untouched entries read as zero.
module multichannel_adc_moving_average_top #(
  parameter int CHANNELS    = acma_pkg::DEF_CHANNELS,
  parameter int TAPS        = acma_pkg::DEF_TAPS,
  parameter int SAMPLE_BITS = acma_pkg::DEF_SAMPLE_BITS,
  localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CW-1:0]          out_channel,
  output logic [SAMPLE_BITS-1:0] out_filtered
);
  import acma_pkg::*;

  localparam int DEPTH = CHANNELS * TAPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(TAPS);
  localparam logic [CW-1:0] CH_LAST   = CW'(CHANNELS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  // Ring slots are laid out as position * CHANNELS + channel, so the write
  // address just counts through the whole memory word by word.
  logic [CW-1:0] ch_r, ch_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          smp_lap_r, smp_lap_nxt;
  logic          sum_lap_r, sum_lap_nxt;
  logic          s1_v_r;
  logic          accept;
  logic          div_busy;

  store_ctl_t       ctl;
  logic [SUM_W-1:0] sum_new;
  logic [CW-1:0]    ch_s1;

  // Hold off during reset, during write-back and while the divide stage is stuck.
  assign in_stall = ~rst_n | s1_v_r | div_busy;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    ch_nxt      = ch_r;
    addr_nxt    = addr_r;
    smp_lap_nxt = smp_lap_r;
    sum_lap_nxt = sum_lap_r;
    if (accept) begin
      // Advance channel and slot; mark a lap once the last one is used.
      ch_nxt   = (ch_r == CH_LAST) ? '0 : ch_r + 1'b1;
      addr_nxt = (addr_r == ADDR_LAST) ? '0 : addr_r + 1'b1;
      if (ch_r == CH_LAST) begin
        sum_lap_nxt = 1'b1;
      end
      if (addr_r == ADDR_LAST) begin
        smp_lap_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r      <= '0;
      addr_r    <= '0;
      smp_lap_r <= 1'b0;
      sum_lap_r <= 1'b0;
      s1_v_r    <= 1'b0;
    end else begin
      ch_r      <= ch_nxt;
      addr_r    <= addr_nxt;
      smp_lap_r <= smp_lap_nxt;
      sum_lap_r <= sum_lap_nxt;
      s1_v_r    <= accept;
    end
  end

  always_comb begin
    ctl.rd_en   = accept;
    ctl.wr_en   = s1_v_r;
    ctl.smp_lap = smp_lap_r;
    ctl.sum_lap = sum_lap_r;
  end

  acma_store #(
    .CHANNELS    (CHANNELS),
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .addr    (addr_r),
    .ch      (ch_r),
    .sample  (in_sample),
    .sum_new (sum_new),
    .ch_out  (ch_s1)
  );

  // The updated sum goes to the divider in the write-back cycle.
  acma_div #(
    .CHANNELS    (CHANNELS),
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (s1_v_r),
    .sum_in       (sum_new),
    .ch_in        (ch_s1),
    .busy         (div_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .out_filtered (out_filtered)
  );

endmodule

>>> hdl/acma_store.sv
// Sample ring memory and per-channel running-sum memory with read-modify-write update.
`timescale 1ns / 1ps

module acma_store #(
  parameter int CHANNELS    = acma_pkg::DEF_CHANNELS,
  parameter int TAPS        = acma_pkg::DEF_TAPS,
  parameter int SAMPLE_BITS = acma_pkg::DEF_SAMPLE_BITS,
  localparam int DEPTH      = CHANNELS * TAPS,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(TAPS)
) (
  input  logic                   clk,
  input  acma_pkg::store_ctl_t   ctl,
  input  logic [AW-1:0]          addr,
  input  logic [CW-1:0]          ch,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SUM_W-1:0]       sum_new,
  output logic [CW-1:0]          ch_out
);
  import acma_pkg::*;

  logic [SAMPLE_BITS-1:0] smp_mem [DEPTH];
  logic [SUM_W-1:0]       sum_mem [CHANNELS];

  logic [SAMPLE_BITS-1:0] old_rd_r;
  logic [SUM_W-1:0]       sum_rd_r;
  logic                   old_ok_r;
  logic                   sum_ok_r;
  logic [AW-1:0]          addr_r;
  logic [CW-1:0]          ch_r;
  logic [SAMPLE_BITS-1:0] smp_r;

  logic [SUM_W-1:0] old_eff;
  logic [SUM_W-1:0] sum_eff;

  // Registered reads of both memories.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      old_rd_r <= smp_mem[addr];
      sum_rd_r <= sum_mem[ch];
    end
  end

  // Write back.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      smp_mem[addr_r] <= smp_r;
      sum_mem[ch_r]   <= sum_new;
    end
  end

  // Hold the word and its location for the write-back cycle.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      old_ok_r <= ctl.smp_lap;
      sum_ok_r <= ctl.sum_lap;
      addr_r   <= addr;
      ch_r     <= ch;
      smp_r    <= sample;
    end
  end

  // Entries not yet written read as zero.
  assign old_eff = old_ok_r ? {{(SUM_W-SAMPLE_BITS){1'b0}}, old_rd_r} : '0;
  assign sum_eff = sum_ok_r ? sum_rd_r : '0;

  // Drop the oldest tap, add the newest; the result always fits SUM_W bits.
  assign sum_new = sum_eff - old_eff + {{(SUM_W-SAMPLE_BITS){1'b0}}, smp_r};
  assign ch_out  = ch_r;

endmodule

>>> hdl/acma_div.sv
// Divide-by-taps stage and output register.
`timescale 1ns / 1ps

module acma_div #(
  parameter int CHANNELS    = acma_pkg::DEF_CHANNELS,
  parameter int TAPS        = acma_pkg::DEF_TAPS,
  parameter int SAMPLE_BITS = acma_pkg::DEF_SAMPLE_BITS,
  localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(TAPS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [SUM_W-1:0]       sum_in,
  input  logic [CW-1:0]          ch_in,
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CW-1:0]          out_channel,
  output logic [SAMPLE_BITS-1:0] out_filtered
);
  // Reciprocal multiply: exact floor for every SUM_W-bit numerator.
  localparam int SHIFT            = SUM_W + $clog2(TAPS);
  localparam int MW               = SUM_W + 2;
  localparam int PW               = SUM_W + MW;
  localparam longint unsigned MUL = ((64'd1 << SHIFT) + TAPS - 1) / TAPS;
  localparam logic [MW-1:0] MUL_C = MUL[MW-1:0];

  logic             s2_v_r, s2_v_nxt;
  logic [SUM_W-1:0] s2_sum_r;
  logic [CW-1:0]    s2_ch_r;
  logic             out_v_r, out_v_nxt;
  logic             move;
  logic [PW-1:0]    prod;

  assign move      = ~out_v_r | ~out_stall;
  assign busy      = s2_v_r & ~move;
  assign s2_v_nxt  = load | (s2_v_r & ~move);
  assign out_v_nxt = s2_v_r | (out_v_r & out_stall);
  assign prod      = {{MW{1'b0}}, s2_sum_r} * {{SUM_W{1'b0}}, MUL_C};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_sum_r <= sum_in;
      s2_ch_r  <= ch_in;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && move) begin
      out_channel  <= s2_ch_r;
      out_filtered <= prod[SHIFT +: SAMPLE_BITS];
    end
  end

  assign out_valid = out_v_r;

endmodule

>>> hdl/acma_checker.sv
// Port-level assertions for the moving-average top level, with its bind.
`timescale 1ns / 1ps

module acma_checker #(
  parameter int CW          = 3,
  parameter int SAMPLE_BITS = 12
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [CW-1:0]          out_channel,
  input logic [SAMPLE_BITS-1:0] out_filtered
);
  logic acc;
  assign acc = rst_n & in_valid & ~in_stall;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_channel) && $stable(out_filtered)))
    else $error("stalled result word changed");

  // The write-back cycle after an accept takes no word.
  a_wb_stall: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> in_stall)
    else $error("word accepted during write-back");

  // Every accepted word is followed by a valid result in the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##3 out_valid)
    else $error("result missing after accept");

  // A result only appears behind an accepted word.
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(acc, 3))
    else $error("result without an accepted word");

endmodule

bind multichannel_adc_moving_average_top acma_checker #(
  .CW          (CW),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_acma_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_channel  (out_channel),
  .out_filtered (out_filtered)
);

>>> tb/sv/multichannel_adc_moving_average_top_test.sv
// Self-checking testbench for the round-robin multichannel moving-average block.
`timescale 1ns / 1ps

module multichannel_adc_moving_average_top_test;

  localparam int CHANNELS    = acma_pkg::DEF_CHANNELS;
  localparam int TAPS        = acma_pkg::DEF_TAPS;
  localparam int SAMPLE_BITS = acma_pkg::DEF_SAMPLE_BITS;
  localparam int CW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW          = (TAPS > 1) ? $clog2(TAPS) : 1;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // Random part: three stretches with different idling, each this many words.
  localparam int PHASE_WORDS = 500;
  // Mode of the random stimulus is redrawn after every group of this size,
  // so that every channel ring can fill completely with one kind of data.
  localparam int GROUP_WORDS = CHANNELS * TAPS;
  // Long receiver hold-off: start once this many words are in, last this long.
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_CYCLES = 200;
  // Watchdog: cycles without any handshake on either side before giving up.
  // Well above the hold-off plus the longest plausible random stall run.
  localparam int STUCK_LIMIT = 2000;
  // Cycles to wait after the last result, allowing for the three-stage pipe.
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    MODE_UNIFORM,
    MODE_FULL_SCALE,
    MODE_ZERO,
    MODE_NEAR_TOP
  } sample_mode_e;

  typedef struct packed {
    logic [CW-1:0]          channel;
    logic [SAMPLE_BITS-1:0] filtered;
  } avg_word_t;

  // Tracks the block's own state: per-channel rings, write positions and the
  // round-robin channel pointer. Every accepted sample yields one average.
  class boxcar_scoreboard;
    bit [SAMPLE_BITS-1:0] rings [CHANNELS][TAPS];
    bit [PW-1:0]          wr_pos [CHANNELS];
    bit [CW-1:0]          cur_ch;
    avg_word_t            averages_due [$];
    int                   errors;

    function void take_sample(logic [SAMPLE_BITS-1:0] sample);
      avg_word_t   avg;
      int unsigned sum;
      int          t;
      rings[cur_ch][wr_pos[cur_ch]] = sample;
      wr_pos[cur_ch] = (wr_pos[cur_ch] == PW'(TAPS - 1)) ? '0 : wr_pos[cur_ch] + 1'b1;
      sum = 0;
      for (t = 0; t < TAPS; t++) sum += rings[cur_ch][t];
      avg.channel  = cur_ch;
      avg.filtered = SAMPLE_BITS'(sum / TAPS);
      averages_due.push_back(avg);
      cur_ch = (cur_ch == CW'(CHANNELS - 1)) ? '0 : cur_ch + 1'b1;
    endfunction

    function void check_average(logic [CW-1:0] channel, logic [SAMPLE_BITS-1:0] filtered);
      avg_word_t want;
      if (averages_due.size() == 0) begin
        $display("%0t: unexpected result, channel %0d filtered %0d",
                 $time, channel, filtered);
        errors++;
        return;
      end
      want = averages_due.pop_front();
      if (channel !== want.channel) begin
        $display("%0t: channel mismatch, expected %0d actual %0d",
                 $time, want.channel, channel);
        errors++;
      end
      if (filtered !== want.filtered) begin
        $display("%0t: filtered mismatch on channel %0d, expected %0d actual %0d",
                 $time, want.channel, want.filtered, filtered);
        errors++;
      end
    endfunction

    function int pending();
      return averages_due.size();
    endfunction
  endclass

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample    = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [CW-1:0]          out_channel;
  logic [SAMPLE_BITS-1:0] out_filtered;

  boxcar_scoreboard sb = new;

  // Idling percentages, set by the stimulus per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int words_taken  = 0;
  int stuck_cycles = 0;

  multichannel_adc_moving_average_top #(
    .CHANNELS   (CHANNELS),
    .TAPS       (TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_filtered(out_filtered)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both handshakes at the rising edge. Note the incoming word before
  // checking the outgoing one; with the pipe depth the order does not matter,
  // but keep it fixed. Count idle cycles for the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.take_sample(in_sample);
        words_taken++;
      end
      if (out_valid && !out_stall) sb.check_average(out_channel, out_filtered);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // Receiver: stall at random per phase, and once hold off for a long
  // stretch so that the divide stage and the output register both fill and
  // the block pushes back on its input while words keep being offered.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && words_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: give up if nothing moves for far too long.
  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one word. Call at a falling edge; return at the falling edge after
  // acceptance. Valid stays high between back-to-back words, so each step
  // sees a single assignment to it.
  task automatic offer_sample(logic [SAMPLE_BITS-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random words: redraw the mode per group so that whole rings fill with
  // full scale or zero and the averages reach both ends of the range.
  task automatic offer_random_phase(int words);
    sample_mode_e           mode;
    logic [SAMPLE_BITS-1:0] sample;
    int                     n;
    mode = MODE_UNIFORM;
    for (n = 0; n < words; n++) begin
      if (n % GROUP_WORDS == 0) begin
        case ($urandom_range(9))
          0:       mode = MODE_FULL_SCALE;
          1:       mode = MODE_ZERO;
          2:       mode = MODE_NEAR_TOP;
          default: mode = MODE_UNIFORM;
        endcase
      end
      case (mode)
        MODE_FULL_SCALE: sample = SAMPLE_MAX;
        MODE_ZERO:       sample = '0;
        MODE_NEAR_TOP:   sample = SAMPLE_MAX - SAMPLE_BITS'($urandom_range(63));
        default:         sample = SAMPLE_BITS'($urandom);
      endcase
      offer_sample(sample);
    end
  endtask

  logic [SAMPLE_BITS-1:0] directed_words [$];

  initial begin
    int n;

    // Hold reset, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Two laps of full scale: the first averages ramp up
    // from zero because the untouched taps still read as zero. Then single
    // bits, alternating patterns and the ends of the range.
    for (n = 0; n < 2 * CHANNELS; n++) directed_words.push_back(SAMPLE_MAX);
    directed_words.push_back(12'hAAA);
    directed_words.push_back(12'h555);
    directed_words.push_back(12'h001);
    directed_words.push_back(12'h800);
    directed_words.push_back(12'h000);
    directed_words.push_back(12'hFFF);
    directed_words.push_back(12'h7FF);
    directed_words.push_back(12'hFFE);

    send_idle_pct = 28;
    recv_idle_pct = 59;
    foreach (directed_words[i]) offer_sample(directed_words[i]);
    offer_random_phase(PHASE_WORDS);

    // Swap the idling round.
    send_idle_pct = 59;
    recv_idle_pct = 28;
    offer_random_phase(PHASE_WORDS);

    // Full rate on both sides; the long hold-off falls in here.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    offer_random_phase(PHASE_WORDS);
    in_valid <= 1'b0;

    // Drain: wait for every average, then let the pipe settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
